@@ design/u2u8_pkg.sv @@
// Shared types, constants and the UTF-8 encoding function of the UTF-16 to UTF-8 transcoder.
// Depends on nothing; used by the top level, the front end, the job queue, the byte emitter and the testbench.
package u2u8_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = $clog2(QDepth);
  localparam int unsigned QCountW = $clog2(QDepth + 1);

  localparam int unsigned MaxBytes = 6;
  localparam int unsigned ByteIdxW = $clog2(MaxBytes);

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast = 16'hDBFF;
  localparam logic [15:0] LowFirst = 16'hDC00;
  localparam logic [15:0] LowLast = 16'hDFFF;
  localparam logic [20:0] SuppBase = 21'h10000;

  localparam logic [20:0] Max1Byte = 21'h7F;
  localparam logic [20:0] Max2Byte = 21'h7FF;
  localparam logic [20:0] Max3Byte = 21'hFFFF;
  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] ContMark = 8'h80;

  // U+FFFD as UTF-8.
  localparam logic [7:0] Repl0 = 8'hEF;
  localparam logic [7:0] Repl1 = 8'hBF;
  localparam logic [7:0] Repl2 = 8'hBD;
  localparam int unsigned ReplLen = 3;

  // One queued job: an optional replacement character first, then an optional code point.
  typedef struct packed {
    logic        repl_first;
    logic        cp_valid;
    logic [20:0] cp;
    logic        last;
  } job_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
  } enc_t;

  function automatic enc_t encode(input logic [20:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp <= Max1Byte) begin
      e.len = 3'd1;
      e.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp <= Max2Byte) begin
      e.len = 3'd2;
      e.bytes[0] = Lead2 | {3'b000, cp[10:6]};
      e.bytes[1] = ContMark | {2'b00, cp[5:0]};
    end else if (cp <= Max3Byte) begin
      e.len = 3'd3;
      e.bytes[0] = Lead3 | {4'b0000, cp[15:12]};
      e.bytes[1] = ContMark | {2'b00, cp[11:6]};
      e.bytes[2] = ContMark | {2'b00, cp[5:0]};
    end else begin
      e.len = 3'd4;
      e.bytes[0] = Lead4 | {5'b00000, cp[20:18]};
      e.bytes[1] = ContMark | {2'b00, cp[17:12]};
      e.bytes[2] = ContMark | {2'b00, cp[11:6]};
      e.bytes[3] = ContMark | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

endpackage

@@ design/utf16_to_utf8_transcoder_top.sv @@
// UTF-16 to UTF-8 transcoder: each item passes through the job queue and the emitter's byte sequence.
// Throughput is one output byte per cycle while the sink is ready; an item yields one to three
// bytes for a BMP character, four for a surrogate pair and up to six with a replacement.
// Input transfers proceed every cycle while the four-entry job queue has room.
// Reset (rst_ni low, asynchronous) empties the queue, drops any held surrogate and the
// byte in flight; all handshake outputs are low, except in_ready_o, which is high.
module utf16_to_utf8_transcoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] code_unit_i,
  input  logic        string_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        run_last_o,
  output logic        text_done_o
);

  // The front end classifies every unit in the cycle of its transfer. It keeps a pending
  // high surrogate in its own register and turns each unit that produces output into a
  // job: an optional U+FFFD for a surrogate that found no partner, followed by an optional
  // code point. Units that only park a high surrogate produce no job at all.
  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  logic           q_full;
  u2u8_pkg::job_t push_job;
  u2u8_pkg::job_t head_job;

  u2u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_unit_i  (code_unit_i),
    .string_end_i (string_end_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_job_o      (push_job)
  );

  // The queue decouples the two halves, so input transfers continue while a long
  // sequence of bytes is still draining on the output side.
  u2u8_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .pop_i      (q_pop),
    .head_job_o (head_job),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  // The emitter encodes the head job into a short byte sequence and moves one byte per
  // cycle into the output register unless the sink stalls. The next job is loaded in the
  // same cycle as the final byte of the current one, so consecutive jobs leave without a gap.
  u2u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .text_done_o (text_done_o)
  );

endmodule

@@ design/u2u8_front.sv @@
// Front end: accepts UTF-16 code units, pairs surrogates and queues code-point jobs.
// Depends on u2u8_pkg.
module u2u8_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        code_unit_i,
  input  logic               string_end_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output u2u8_pkg::job_t     q_job_o
);

  logic       held_valid_q, held_valid_d;
  logic [9:0] held_bits_q, held_bits_d;
  logic       accept;
  logic       is_high, is_low;

  assign in_ready_o = !q_full_i;
  assign accept = in_valid_i && in_ready_o;
  assign is_high = (code_unit_i >= u2u8_pkg::HighFirst) && (code_unit_i <= u2u8_pkg::HighLast);
  assign is_low = (code_unit_i >= u2u8_pkg::LowFirst) && (code_unit_i <= u2u8_pkg::LowLast);

  always_comb begin
    q_job_o.last = string_end_i;
    q_job_o.repl_first = 1'b0;
    q_job_o.cp_valid = 1'b1;
    q_job_o.cp = {5'd0, code_unit_i};
    if (held_valid_q && is_low) begin
      q_job_o.cp = u2u8_pkg::SuppBase + {1'b0, held_bits_q, code_unit_i[9:0]};
    end else begin
      q_job_o.repl_first = held_valid_q;
      if (is_high) begin
        // A high surrogate ending the string becomes U+FFFD; otherwise it waits.
        q_job_o.cp_valid = string_end_i;
        q_job_o.cp = {5'd0, 16'hFFFD};
      end else if (is_low) begin
        q_job_o.cp = {5'd0, 16'hFFFD};
      end
    end
  end

  assign q_push_o = accept && (q_job_o.repl_first || q_job_o.cp_valid);

  always_comb begin
    held_valid_d = held_valid_q;
    held_bits_d = held_bits_q;
    if (accept) begin
      held_valid_d = is_high && !string_end_i;
      held_bits_d = is_high ? code_unit_i[9:0] : 10'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_bits_q <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_bits_q <= held_bits_d;
    end
  end

endmodule

@@ design/u2u8_queue.sv @@
// Short job queue between the front end and the byte emitter.
// Depends on u2u8_pkg for the job type and depth.
module u2u8_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  u2u8_pkg::job_t push_job_i,
  input  logic           pop_i,
  output u2u8_pkg::job_t head_job_o,
  output logic           empty_o,
  output logic           full_o
);

  u2u8_pkg::job_t                     mem_q [u2u8_pkg::QDepth];
  logic [u2u8_pkg::QAddrW-1:0]        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [u2u8_pkg::QCountW-1:0]       count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o = (count_q == u2u8_pkg::QCountW'(u2u8_pkg::QDepth));
  assign head_job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

@@ design/u2u8_back.sv @@
// Byte emitter: encodes queued jobs to UTF-8 and sends one byte per cycle while not stalled.
// Depends on u2u8_pkg for the job type and the encoding function.
module u2u8_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  u2u8_pkg::job_t job_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           run_last_o,
  output logic           text_done_o
);

  logic [u2u8_pkg::MaxBytes-1:0][7:0] seq_q, seq_d;
  logic [2:0]                         cnt_q, cnt_d;
  logic [u2u8_pkg::ByteIdxW-1:0]      idx_q, idx_d;
  logic                               busy_q, busy_d;
  logic                               last_q, last_d;
  logic                               out_valid_q, out_valid_d;
  logic [7:0]                         out_byte_q, out_byte_d;
  logic                               run_last_q, run_last_d;
  logic                               done_q, done_d;
  logic                               issue, fin;
  u2u8_pkg::enc_t                     enc;
  logic [7:0]                         repl [u2u8_pkg::ReplLen];

  assign repl[0] = u2u8_pkg::Repl0;
  assign repl[1] = u2u8_pkg::Repl1;
  assign repl[2] = u2u8_pkg::Repl2;

  assign enc = u2u8_pkg::encode(job_i.cp);
  assign issue = busy_q && (!out_valid_q || out_ready_i);
  assign fin = issue && (idx_q == cnt_q - 3'd1);
  assign q_pop_o = !q_empty_i && (!busy_q || fin);

  always_comb begin
    seq_d = seq_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    busy_d = busy_q;
    last_d = last_q;
    if (issue) begin
      idx_d = idx_q + 1'b1;
      if (fin) begin
        busy_d = 1'b0;
      end
    end
    if (q_pop_o) begin
      busy_d = 1'b1;
      idx_d = '0;
      last_d = job_i.last;
      for (int i = 0; i < u2u8_pkg::MaxBytes; i++) begin
        if (job_i.repl_first) begin
          if (i < u2u8_pkg::ReplLen) begin
            seq_d[i] = repl[i];
          end else begin
            seq_d[i] = enc.bytes[i-u2u8_pkg::ReplLen];
          end
        end else begin
          seq_d[i] = (i < 4) ? enc.bytes[i] : 8'd0;
        end
      end
      if (job_i.repl_first) begin
        cnt_d = job_i.cp_valid ? (3'(u2u8_pkg::ReplLen) + enc.len) : 3'(u2u8_pkg::ReplLen);
      end else begin
        cnt_d = enc.len;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d = out_byte_q;
    run_last_d = run_last_q;
    done_d = done_q;
    if (issue) begin
      out_valid_d = 1'b1;
      out_byte_d = seq_q[idx_q];
      run_last_d = fin;
      done_d = fin && last_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q <= seq_d;
    last_q <= last_d;
    out_byte_q <= out_byte_d;
    run_last_q <= run_last_d;
    done_q <= done_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o = out_byte_q;
  assign run_last_o = run_last_q;
  assign text_done_o = done_q;

endmodule

@@ design/u2u8_checker.sv @@
// Port-level checks for the UTF-16 to UTF-8 transcoder, bound to its top level.
// Depends only on the top level's ports.
module u2u8_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [15:0] code_unit_i,
  input logic        string_end_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_o,
  input logic        run_last_o,
  input logic        text_done_o
);

  // A waiting input transfer keeps its valid and its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(code_unit_i)
      && $stable(string_end_i))
  else $error("stalled input transfer changed");

  // A stalled byte holds its value and flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(run_last_o) && $stable(text_done_o))
  else $error("stalled output transfer changed");

  // The end of a string is always the end of an item's bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_done_o |-> run_last_o)
  else $error("text_done without run_last");

  // A UTF-8 lead byte of a multi-byte sequence is never the last byte of an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_byte_o[7:6] == 2'b11 |-> !run_last_o)
  else $error("item ended on a lead byte");

  // The bytes of one item leave back to back once the sink takes them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> out_valid_o)
  else $error("gap inside an item's byte sequence");

endmodule

bind utf16_to_utf8_transcoder_top u2u8_checker u_u2u8_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .code_unit_i  (code_unit_i),
  .string_end_i (string_end_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_byte_o   (out_byte_o),
  .run_last_o   (run_last_o),
  .text_done_o  (text_done_o)
);

@@ verif/utf16_to_utf8_transcoder_top_tb.sv @@
// Self-checking testbench for utf16_to_utf8_transcoder_top: directed table, then random strings.
// Depends on design/u2u8_pkg.sv for the surrogate range constants and on the design under test.
module utf16_to_utf8_transcoder_top_tb;

  localparam int RandomUnits = 500;
  localparam int ReportLimit = 10;
  localparam int DrainCycles = 20;
  localparam int DefaultIdlePct = 30;

  // Up to six UTF-8 bytes per code unit, first byte at index 0.
  typedef logic [0:5][7:0] byte_seq_t;

  // One row of stimulus. When has_fixed is set, the expected bytes are written out by hand
  // in fixed_bytes; otherwise the transcoding predictor supplies them.
  typedef struct packed {
    logic [15:0] unit;
    logic        last;
    logic        has_fixed;
    logic [2:0]  fixed_count;
    byte_seq_t   fixed_bytes;
  } unit_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_done;
  } utf8_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [15:0] code_unit_i;
  logic        string_end_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        run_last_o;
  logic        text_done_o;

  // Predictor state: a high surrogate waiting for its partner.
  logic       held_pending;
  logic [9:0] held_bits;

  utf8_byte_t pending_bytes_q[$];
  unit_row_t  directed_q[$];
  utf8_byte_t got_byte;
  utf8_byte_t want_byte;

  int idle_pct = DefaultIdlePct;
  int mismatches = 0;
  int units_sent = 0;
  int strings_sent = 0;
  int pairs_sent = 0;
  int bytes_checked = 0;

  utf16_to_utf8_transcoder_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .code_unit_i  (code_unit_i),
    .string_end_i (string_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .text_done_o  (text_done_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Appends the UTF-8 form of one code point to the byte sequence.
  function automatic void add_code_point(input logic [20:0] cp, inout logic [2:0] n,
                                         inout byte_seq_t seq);
    if (cp <= 21'h7F) begin
      seq[n] = {1'b0, cp[6:0]};
      n = n + 3'd1;
    end else if (cp <= 21'h7FF) begin
      seq[n] = {3'b110, cp[10:6]};
      seq[n + 3'd1] = {2'b10, cp[5:0]};
      n = n + 3'd2;
    end else if (cp <= 21'hFFFF) begin
      seq[n] = {4'b1110, cp[15:12]};
      seq[n + 3'd1] = {2'b10, cp[11:6]};
      seq[n + 3'd2] = {2'b10, cp[5:0]};
      n = n + 3'd3;
    end else begin
      seq[n] = {5'b11110, cp[20:18]};
      seq[n + 3'd1] = {2'b10, cp[17:12]};
      seq[n + 3'd2] = {2'b10, cp[11:6]};
      seq[n + 3'd3] = {2'b10, cp[5:0]};
      n = n + 3'd4;
    end
  endfunction

  // Works out the bytes that one accepted code unit yields and advances the held surrogate.
  function automatic void transcode_unit(input logic [15:0] unit, input logic last,
                                         output logic [2:0] n, output byte_seq_t seq);
    logic is_high;
    logic is_low;
    n = 3'd0;
    seq = '0;
    is_high = (unit >= u2u8_pkg::HighFirst) && (unit <= u2u8_pkg::HighLast);
    is_low = (unit >= u2u8_pkg::LowFirst) && (unit <= u2u8_pkg::LowLast);
    if (held_pending) begin
      held_pending = 1'b0;
      if (is_low) begin
        add_code_point(21'h10000 + {1'b0, held_bits, unit[9:0]}, n, seq);
        held_bits = '0;
        return;
      end
      // The partner never came, so the waiting surrogate becomes a replacement character.
      held_bits = '0;
      add_code_point(21'hFFFD, n, seq);
    end
    if (is_high) begin
      if (last) begin
        add_code_point(21'hFFFD, n, seq);
      end else begin
        held_pending = 1'b1;
        held_bits = unit[9:0];
      end
    end else if (is_low) begin
      add_code_point(21'hFFFD, n, seq);
    end else begin
      add_code_point({5'd0, unit}, n, seq);
    end
  endfunction

  function automatic unit_row_t fixed_row(input logic [15:0] unit, input logic last,
                                          input logic [2:0] count, input byte_seq_t seq);
    unit_row_t r;
    r.unit = unit;
    r.last = last;
    r.has_fixed = 1'b1;
    r.fixed_count = count;
    r.fixed_bytes = seq;
    return r;
  endfunction

  function automatic unit_row_t open_row(input logic [15:0] unit, input logic last);
    unit_row_t r;
    r = '0;
    r.unit = unit;
    r.last = last;
    return r;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(input unit_row_t r);
    directed_q.insert(directed_q.size(), r);
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endfunction

  function automatic logic idle_draw();
    return ($urandom_range(99) < idle_pct);
  endfunction

  // Presents one code unit, holds it until the transfer, then queues the expected bytes.
  task automatic send_unit(input unit_row_t r);
    logic [2:0] n;
    byte_seq_t  seq;
    while (idle_draw()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    code_unit_i <= r.unit;
    string_end_i <= r.last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    transcode_unit(r.unit, r.last, n, seq);
    // Hand-written rows overrule the predictor, which still tracks the held surrogate.
    if (r.has_fixed) begin
      n = r.fixed_count;
      seq = r.fixed_bytes;
    end
    for (int i = 0; i < n; i++) begin
      pending_bytes_q.insert(pending_bytes_q.size(),
                             {seq[i], (i == n - 1), (i == n - 1) && r.last});
    end
    units_sent++;
    if (r.last) strings_sent++;
  endtask

  // Output side: checks every transfer against the oldest expectation and stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      got_byte = {out_byte_o, run_last_o, text_done_o};
      if (pending_bytes_q.size() == 0) begin
        note_mismatch($sformatf("byte %02h run_last %b text_done %b with nothing expected",
                                out_byte_o, run_last_o, text_done_o));
      end else begin
        want_byte = pending_bytes_q.pop_front();
        bytes_checked++;
        if (got_byte.data !== want_byte.data || got_byte.run_last !== want_byte.run_last ||
            got_byte.text_done !== want_byte.text_done) begin
          note_mismatch($sformatf(
              "byte exp %02h got %02h, run_last exp %b got %b, text_done exp %b got %b",
              want_byte.data, got_byte.data, want_byte.run_last, got_byte.run_last,
              want_byte.text_done, got_byte.text_done));
        end
      end
    end
    out_ready_i <= !idle_draw();
  end

  initial begin
    logic [15:0] lead;
    logic [15:0] tail;
    int          kind;
    int          chars_left;
    logic        ends;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    code_unit_i = '0;
    string_end_i = 1'b0;
    held_pending = 1'b0;
    held_bits = '0;

    // Edges of each UTF-8 length, surrogate pairs at both ends of the range, and every way
    // a surrogate can be left without its partner.
    add_row(fixed_row(16'h0000, 1'b0, 3'd1, 48'h00_00_00_00_00_00));
    add_row(fixed_row(16'h007F, 1'b1, 3'd1, 48'h7F_00_00_00_00_00));
    add_row(fixed_row(16'h0080, 1'b0, 3'd2, 48'hC2_80_00_00_00_00));
    add_row(fixed_row(16'h07FF, 1'b0, 3'd2, 48'hDF_BF_00_00_00_00));
    add_row(fixed_row(16'h0800, 1'b0, 3'd3, 48'hE0_A0_80_00_00_00));
    add_row(fixed_row(16'hD7FF, 1'b0, 3'd3, 48'hED_9F_BF_00_00_00));
    add_row(fixed_row(16'hE000, 1'b0, 3'd3, 48'hEE_80_80_00_00_00));
    add_row(fixed_row(16'hFFFF, 1'b1, 3'd3, 48'hEF_BF_BF_00_00_00));
    // A low surrogate on its own, mid-string and at the end of a string.
    add_row(fixed_row(16'hDC00, 1'b0, 3'd3, 48'hEF_BF_BD_00_00_00));
    add_row(fixed_row(16'hDFFF, 1'b1, 3'd3, 48'hEF_BF_BD_00_00_00));
    // Lowest and highest supplementary code points; the high half yields nothing.
    add_row(fixed_row(16'hD800, 1'b0, 3'd0, 48'h0));
    add_row(fixed_row(16'hDC00, 1'b0, 3'd4, 48'hF0_90_80_80_00_00));
    add_row(fixed_row(16'hDBFF, 1'b0, 3'd0, 48'h0));
    add_row(fixed_row(16'hDFFF, 1'b1, 3'd4, 48'hF4_8F_BF_BF_00_00));
    // A high surrogate that closes a string is replaced at once.
    add_row(fixed_row(16'hDBFF, 1'b1, 3'd3, 48'hEF_BF_BD_00_00_00));
    // A waiting high surrogate displaced by another one, then by an ASCII character.
    add_row(fixed_row(16'hD800, 1'b0, 3'd0, 48'h0));
    add_row(fixed_row(16'hDBFF, 1'b0, 3'd3, 48'hEF_BF_BD_00_00_00));
    add_row(fixed_row(16'h0041, 1'b0, 3'd4, 48'hEF_BF_BD_41_00_00));
    // Six bytes from one unit: replacement followed by a three-byte character.
    add_row(fixed_row(16'hD9AB, 1'b0, 3'd0, 48'h0));
    add_row(fixed_row(16'hFFFF, 1'b1, 3'd6, 48'hEF_BF_BD_EF_BF_BF));
    // Waiting surrogate displaced by a high surrogate that itself ends the string.
    add_row(fixed_row(16'hDABC, 1'b0, 3'd0, 48'h0));
    add_row(fixed_row(16'hDBFF, 1'b1, 3'd6, 48'hEF_BF_BD_EF_BF_BD));
    add_row(open_row(16'hD83D, 1'b0));
    add_row(open_row(16'hDE00, 1'b1));
    add_row(open_row(16'h12A5, 1'b1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) send_unit(directed_q[i]);
    pairs_sent = 3;

    // Random strings of one to eight characters: mostly well-formed text of every UTF-8
    // length, with stray surrogates and arbitrary units mixed in.
    chars_left = 0;
    while (units_sent < directed_q.size() + RandomUnits) begin
      // A stretch in the middle with neither side idling.
      idle_pct = (units_sent >= 200 && units_sent < 300) ? 0 : DefaultIdlePct;
      if (chars_left == 0) chars_left = $urandom_range(8, 1);
      ends = (chars_left == 1);
      chars_left--;
      kind = $urandom_range(99);
      if (kind < 20) begin
        send_unit(open_row(16'($urandom_range(16'h007F)), ends));
      end else if (kind < 35) begin
        send_unit(open_row(16'($urandom_range(16'h07FF, 16'h0080)), ends));
      end else if (kind < 55) begin
        lead = $urandom_range(1) ? 16'($urandom_range(16'hD7FF, 16'h0800))
                                 : 16'($urandom_range(16'hFFFF, 16'hE000));
        send_unit(open_row(lead, ends));
      end else if (kind < 78) begin
        lead = 16'($urandom_range(u2u8_pkg::HighLast, u2u8_pkg::HighFirst));
        tail = 16'($urandom_range(u2u8_pkg::LowLast, u2u8_pkg::LowFirst));
        send_unit(open_row(lead, 1'b0));
        send_unit(open_row(tail, ends));
        pairs_sent++;
      end else if (kind < 85) begin
        send_unit(open_row(16'($urandom_range(u2u8_pkg::LowLast, u2u8_pkg::LowFirst)), ends));
      end else if (kind < 92) begin
        send_unit(open_row(16'($urandom_range(u2u8_pkg::HighLast, u2u8_pkg::HighFirst)),
                           ends));
      end else begin
        send_unit(open_row(16'($urandom_range(16'hFFFF)), ends));
      end
    end
    in_valid_i <= 1'b0;
    idle_pct = DefaultIdlePct;

    while (pending_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d code units in %0d strings, %0d of them surrogate pairs;",
             units_sent, strings_sent, pairs_sent);
    $display("checked %0d UTF-8 bytes, %0d mismatches.", bytes_checked, mismatches);
    if (mismatches == 0) begin
      $display("utf16_to_utf8_transcoder_top test passed");
    end else begin
      $display("utf16_to_utf8_transcoder_top test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #4000000;
    $display("Timed out with %0d bytes still expected.", pending_bytes_q.size());
    $display("utf16_to_utf8_transcoder_top test failed");
    $finish;
  end

endmodule

@@ files.f @@
design/u2u8_pkg.sv
design/u2u8_front.sv
design/u2u8_queue.sv
design/u2u8_back.sv
design/utf16_to_utf8_transcoder_top.sv
design/u2u8_checker.sv
verif/utf16_to_utf8_transcoder_top_tb.sv
